// File: hdl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked and held off during reset.
`define FRS_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("frs check failed");

// Next-cycle implication, clocked and held off during reset.
`define FRS_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("frs check failed");

`endif

// File: hdl/frs_pkg.sv
// Package: types, codes and sizes of the fax receive training sequencer.
`timescale 1ns / 1ps

package frs_pkg;

  localparam int UNIT_BITS   = 10;
  localparam int BUDGET_BITS = 16;

  localparam int UNITS_W  = 10;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_EPOCH = 3'd1,
    PH_PROTO = 3'd2,
    PH_DATA  = 3'd3,
    PH_IDLE  = 3'd4,
    PH_ERROR = 3'd5
  } phase_t;

  typedef logic [2:0] status_t;
  localparam status_t ST_START = 3'd0;
  localparam status_t ST_TRAIN = 3'd1;
  localparam status_t ST_LOST  = 3'd2;
  localparam status_t ST_DATA  = 3'd3;
  localparam status_t ST_D9600 = 3'd4;
  localparam status_t ST_D7200 = 3'd5;
  localparam status_t ST_IDLE  = 3'd6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EPOCH_BUDGET    = 2'd0,
    REG_PROTOCOL_BUDGET = 2'd1,
    REG_SNR_THRESHOLD   = 2'd2,
    REG_MSE_RECOVERED   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [14:0]        epoch_budget;
    logic [14:0]        protocol_budget;
    logic signed [15:0] snr_threshold;
    logic [14:0]        mse_recovered;
  } cfg_t;

  // bit 0 carrier up to bit 4 data
  typedef struct packed {
    logic data;
    logic idle;
    logic low_snr;
    logic error;
    logic carrier;
  } flags_t;

  typedef struct packed {
    phase_t                 phase;
    logic [BUDGET_BITS-1:0] budget;
    status_t                status;
    flags_t                 flags;
  } seq_state_t;

  typedef struct packed {
    logic               carrier_seen;
    logic               data_carrier_seen;
    logic               quality_lost;
    logic               epoch_seen;
    logic signed [15:0] snr_value;
    logic [14:0]        mse_value;
    logic               rate_is_7200;
    logic [UNITS_W-1:0] units_made;
    logic               idle_request;
  } item_t;

  typedef struct packed {
    logic [UNITS_W-1:0] units_out;
    status_t            status_code;
    flags_t             flags;
    logic               demod_on;
    logic               descramble_on;
    logic               agc_step;
    logic               agc_freeze;
    phase_t             state_now;
  } result_t;

endpackage

// File: hdl/frs_cfg.sv
// Configuration register file of the sequencer.
`timescale 1ns / 1ps

module frs_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [frs_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [frs_pkg::CFG_W-1:0]      cfg_wdata,
  output frs_pkg::cfg_t                  cfg
);
  import frs_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        REG_EPOCH_BUDGET:    cfg_nxt.epoch_budget    = cfg_wdata[14:0];
        REG_PROTOCOL_BUDGET: cfg_nxt.protocol_budget = cfg_wdata[14:0];
        REG_SNR_THRESHOLD:   cfg_nxt.snr_threshold   = $signed(cfg_wdata);
        REG_MSE_RECOVERED:   cfg_nxt.mse_recovered   = cfg_wdata[14:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.epoch_budget    <= 15'd64;
      cfg_r.protocol_budget <= 15'd64;
      cfg_r.snr_threshold   <= '0;
      cfg_r.mse_recovered   <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: hdl/frs_step.sv
// Per-block decision logic: next sequencer state and the result beat.
`timescale 1ns / 1ps

module frs_step (
  input  frs_pkg::cfg_t       cfg,
  input  frs_pkg::seq_state_t st,
  input  frs_pkg::item_t      item,
  output frs_pkg::seq_state_t st_nxt,
  output frs_pkg::result_t    res
);
  import frs_pkg::*;

  seq_state_t             nx;
  logic [BUDGET_BITS-1:0] b_dec;
  logic                   alive;
  logic                   snr_low;
  status_t                rate_st;
  logic [UNITS_W-1:0]     made;
  logic [UNITS_W-1:0]     units;
  logic                   demod;
  logic                   descr;
  logic                   step;
  logic                   freeze;

  assign b_dec   = st.budget - 1'b1;
  assign alive   = (b_dec != '0) && !b_dec[BUDGET_BITS-1];
  assign snr_low = $signed(item.snr_value) <= $signed(cfg.snr_threshold);
  assign rate_st = item.rate_is_7200 ? ST_D7200 : ST_D9600;
  // reported units are limited to UNIT_BITS
  assign made    = UNITS_W'(UNIT_BITS'(item.units_made));

  always_comb begin
    nx     = st;
    units  = '0;
    demod  = 1'b1;
    descr  = 1'b0;
    step   = 1'b0;
    freeze = 1'b0;
    nx.flags.error = 1'b0;

    unique case (st.phase)
      PH_START: begin
        nx.flags.carrier = 1'b0;
        nx.status        = ST_START;
        if (item.carrier_seen) begin
          nx.flags.carrier = 1'b1;
          nx.budget        = BUDGET_BITS'(cfg.epoch_budget);
          nx.phase         = PH_EPOCH;
          nx.flags.idle    = 1'b0;
          nx.flags.data    = 1'b0;
        end
      end
      PH_EPOCH: begin
        if (!item.carrier_seen) begin
          nx.phase         = PH_ERROR;
          nx.flags.error   = 1'b1;
          nx.flags.carrier = 1'b0;
          nx.status        = ST_LOST;
        end else begin
          nx.flags.carrier = 1'b1;
          nx.status        = ST_TRAIN;
          nx.budget        = b_dec;
          // move on when the epoch is seen or the budget runs out
          if (!alive || item.epoch_seen) begin
            nx.budget     = BUDGET_BITS'(cfg.protocol_budget);
            nx.phase      = PH_PROTO;
            nx.flags.idle = 1'b0;
            nx.flags.data = 1'b0;
            step          = 1'b1;
          end
        end
      end
      PH_PROTO: begin
        descr = 1'b1;
        if (!item.carrier_seen) begin
          nx.phase         = PH_ERROR;
          nx.flags.error   = 1'b1;
          nx.flags.carrier = 1'b0;
          nx.status        = ST_LOST;
        end else begin
          nx.flags.carrier = 1'b1;
          nx.status        = ST_TRAIN;
          nx.budget        = b_dec;
          if (!alive) begin
            // handover to data
            nx.status = rate_st;
            if (snr_low) nx.flags.low_snr = 1'b1;
            freeze        = 1'b1;
            nx.budget     = '0;
            nx.phase      = PH_DATA;
            nx.flags.idle = 1'b0;
            nx.flags.data = 1'b1;
            units         = made;
          end
        end
      end
      PH_DATA: begin
        nx.status = ST_DATA;
        if (!item.data_carrier_seen) begin
          nx.flags.carrier = 1'b0;
          demod            = 1'b0;
        end else begin
          nx.flags.carrier = 1'b1;
          descr            = 1'b1;
          units            = item.quality_lost ? '0 : made;
          nx.flags.low_snr = snr_low;
        end
      end
      PH_IDLE: begin
        nx.status        = ST_IDLE;
        nx.flags.carrier = item.carrier_seen;
        if (item.carrier_seen && (item.mse_value <= cfg.mse_recovered)) begin
          nx.phase      = PH_DATA;
          nx.flags.idle = 1'b0;
          nx.flags.data = 1'b1;
          nx.status     = rate_st;
        end
      end
      default: begin
        // error trap, and the unused codes behave the same
        nx.phase       = PH_ERROR;
        nx.flags.error = 1'b1;
      end
    endcase

    if (item.idle_request && nx.phase == PH_DATA) begin
      nx.phase      = PH_IDLE;
      nx.budget     = '0;
      nx.flags.idle = 1'b1;
      nx.flags.data = 1'b0;
    end
  end

  assign st_nxt            = nx;
  assign res.units_out     = units;
  assign res.status_code   = nx.status;
  assign res.flags         = nx.flags;
  assign res.demod_on      = demod;
  assign res.descramble_on = descr;
  assign res.agc_step      = step;
  assign res.agc_freeze    = freeze;
  assign res.state_now     = nx.phase;

endmodule

// File: hdl/fax_rx_training_sequencer_top.sv
// Top level of the fax receive training sequencer.
`timescale 1ns / 1ps

// Fax receive training sequencer: one input beat per demodulated block, one
// result beat per input beat. Throughput is one block per clock unless
// out_stall is raised; each block passes an input register and a result
// register with the whole per-block decision (state walk, budget countdown,
// flag and strobe update) combinational between them. The sequencer state
// loads with the result register, so consecutive blocks follow without a
// gap. in_stall rises only while the input register holds a block and the
// result register is full and stalled. Configuration is written through
// cfg_we/cfg_idx/cfg_wdata and takes effect from the next block; write
// only while no block is in flight. There is no clearing pass after reset.
module fax_rx_training_sequencer_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_idx,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_carrier_seen,
  input  logic               in_data_carrier_seen,
  input  logic               in_quality_lost,
  input  logic               in_epoch_seen,
  input  logic signed [15:0] in_snr_value,
  input  logic [14:0]        in_mse_value,
  input  logic               in_rate_is_7200,
  input  logic [9:0]         in_units_made,
  input  logic               in_idle_request,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [9:0]         out_units_out,
  output logic [2:0]         out_status_code,
  output logic               out_carrier_flag,
  output logic               out_error_flag,
  output logic               out_low_snr_flag,
  output logic               out_idle_flag,
  output logic               out_data_flag,
  output logic               out_demod_on,
  output logic               out_descramble_on,
  output logic               out_agc_step,
  output logic               out_agc_freeze,
  output logic [2:0]         out_state_now
);
  import frs_pkg::*;

  cfg_t       cfg;
  item_t      item_r;
  logic       s1_vld_r;
  logic       s1_vld_nxt;
  seq_state_t st_r;
  seq_state_t st_nxt;
  result_t    res;
  result_t    res_r;
  logic       out_vld_r;
  logic       out_vld_nxt;
  logic       out_load;
  logic       in_take;

  frs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  frs_step u_step (
    .cfg    (cfg),
    .st     (st_r),
    .item   (item_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  // result register can take a beat when empty or being drained
  assign out_load    = s1_vld_r && (!out_vld_r || !out_stall);
  assign in_stall    = s1_vld_r && !out_load;
  assign in_take     = in_valid && !in_stall;
  assign s1_vld_nxt  = in_take || (s1_vld_r && !out_load);
  assign out_vld_nxt = out_load || (out_vld_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      st_r      <= '{phase: PH_START, budget: '0, status: ST_START, flags: '0};
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (out_load) st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.carrier_seen      <= in_carrier_seen;
      item_r.data_carrier_seen <= in_data_carrier_seen;
      item_r.quality_lost      <= in_quality_lost;
      item_r.epoch_seen        <= in_epoch_seen;
      item_r.snr_value         <= in_snr_value;
      item_r.mse_value         <= in_mse_value;
      item_r.rate_is_7200      <= in_rate_is_7200;
      item_r.units_made        <= in_units_made;
      item_r.idle_request      <= in_idle_request;
    end
    if (out_load) res_r <= res;
  end

  assign out_valid         = out_vld_r;
  assign out_units_out     = res_r.units_out;
  assign out_status_code   = res_r.status_code;
  assign out_carrier_flag  = res_r.flags.carrier;
  assign out_error_flag    = res_r.flags.error;
  assign out_low_snr_flag  = res_r.flags.low_snr;
  assign out_idle_flag     = res_r.flags.idle;
  assign out_data_flag     = res_r.flags.data;
  assign out_demod_on      = res_r.demod_on;
  assign out_descramble_on = res_r.descramble_on;
  assign out_agc_step      = res_r.agc_step;
  assign out_agc_freeze    = res_r.agc_freeze;
  assign out_state_now     = res_r.state_now;

endmodule

// File: hdl/frs_chk.sv
// Port-level checker for the sequencer top, bound in below.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module frs_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [9:0] out_units_out,
  input logic       out_error_flag,
  input logic       out_idle_flag,
  input logic       out_data_flag,
  input logic       out_descramble_on,
  input logic       out_agc_freeze,
  input logic [2:0] out_state_now
);
  import frs_pkg::*;

  // error is only ever reported from the error trap
  `FRS_ASSERT_NOW(a_err_in_trap, clk, rst_n, out_valid && out_error_flag, out_state_now == PH_ERROR)
  // the handover beat lands in data, or in idle on a same-block request
  `FRS_ASSERT_NOW(a_freeze_lands, clk, rst_n, out_valid && out_agc_freeze, out_data_flag != out_idle_flag)
  // units are only reported while the descrambler runs
  `FRS_ASSERT_NOW(a_units_descr, clk, rst_n, out_valid && (out_units_out != '0), out_descramble_on)
  // a stalled result beat holds
  `FRS_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_units_out) && $stable(out_state_now))

endmodule

bind fax_rx_training_sequencer_top frs_chk u_frs_chk (.*);
